// File: hw/rtl/btdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btdl_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned MsW    = 16;
	localparam int unsigned SlotW  = 8;
	localparam int unsigned CfgIdxW = 8;

	localparam logic [MsW-1:0]   LongPressRst  = MsW'(2000);
	localparam logic [MsW-1:0]   DoubleTapRst  = MsW'(500);
	localparam logic [SlotW-1:0] StartSlotRst  = '0;
	localparam logic             StopEnRst     = 1'b1;

	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_DOUBLE_TAP = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] CFG_START_SLOT = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CFG_STOP_EN    = CfgIdxW'(3);

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_STOP     = 2'd1,
		ACT_START    = 2'd2,
		ACT_SHUTDOWN = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PAIR_KEEP    = 2'd0,
		PAIR_DISABLE = 2'd1,
		PAIR_ENABLE  = 2'd2
	} pairing_t;

	// gesture flags, cleared by reset
	typedef struct packed {
		logic seen_release;
		logic was_down;
		logic press_counts;
		logic long_done;
		logic tap_armed;
		logic status_flag;
	} flags_t;

	typedef struct packed {
		logic [MsW-1:0]   long_press_ms;
		logic [MsW-1:0]   double_tap_ms;
		logic [SlotW-1:0] start_slot;
		logic             stop_enabled;
	} cfg_t;

	typedef struct packed {
		action_t          action;
		pairing_t         pairing;
		logic [SlotW-1:0] slot;
		logic             pressed;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/button_tap_doubletap_longpress.sv
`timescale 1ns / 1ps
`default_nettype none

// Power-button gesture detector: tap, double tap and long press.
// Input channel (in_valid/in_ready): one poll tick per item with now_ms,
// read_ok, button_down and prog_active.
// Output channel (out_valid/out_ready): exactly one result item per tick with
// action, pairing_command, program_slot and pressed_status.
// Config channel (cfg_valid/cfg_ready): cfg_index selects long_press_ms (0),
// double_tap_ms (1), start_slot (2) or stop_enabled (3); other indexes are
// dropped. cfg_ready is always high. Write only while the block is idle.
// Path: an accepted tick is held in the input register, then its result in the
// result register. Throughput: one item per cycle while out_ready is high; the
// whole gesture update is one combinational pass between the two registers.
// Stall: while out_ready is low the result holds; one more tick can sit in
// the input register, after which in_ready drops.
// Reset: gesture state clears, so a press held from power-on is ignored until
// a first release; registers return to 2000 ms, 500 ms, slot 0, stop enabled.
module button_tap_doubletap_longpress (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [btdl_pkg::TimeW-1:0]     now_ms,
	input  wire logic                           read_ok,
	input  wire logic                           button_down,
	input  wire logic                           prog_active,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          action,
	output logic [1:0]                          pairing_command,
	output logic [btdl_pkg::SlotW-1:0]          program_slot,
	output logic                                pressed_status,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [btdl_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [btdl_pkg::MsW-1:0]       cfg_data
);
	import btdl_pkg::*;

	cfg_t             cfg_q;
	flags_t           flags_q;
	flags_t           flags_nxt;
	logic [TimeW-1:0] tap_time_q;
	logic [TimeW-1:0] press_start_q;
	logic [TimeW-1:0] tap_time_nxt;
	logic [TimeW-1:0] press_start_nxt;

	logic             valid_s1;
	logic [TimeW-1:0] now_s1;
	logic             ok_s1;
	logic             down_s1;
	logic             run_s1;

	logic             out_valid_q;
	result_t          res;
	result_t          res_q;
	logic             advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms <= LongPressRst;
			cfg_q.double_tap_ms <= DoubleTapRst;
			cfg_q.start_slot    <= StartSlotRst;
			cfg_q.stop_enabled  <= StopEnRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				CFG_DOUBLE_TAP: cfg_q.double_tap_ms <= cfg_data;
				CFG_START_SLOT: cfg_q.start_slot    <= cfg_data[SlotW-1:0];
				CFG_STOP_EN:    cfg_q.stop_enabled  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1  <= now_ms;
			ok_s1   <= read_ok;
			down_s1 <= button_down;
			run_s1  <= prog_active;
		end
	end

	btdl_step u_step (
		.cfg              (cfg_q),
		.flags            (flags_q),
		.tap_time         (tap_time_q),
		.press_start_time (press_start_q),
		.now_ms           (now_s1),
		.read_ok          (ok_s1),
		.button_down      (down_s1),
		.prog_active      (run_s1),
		.flags_nxt        (flags_nxt),
		.tap_time_nxt     (tap_time_nxt),
		.press_start_nxt  (press_start_nxt),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tap_time_q    <= tap_time_nxt;
			press_start_q <= press_start_nxt;
			res_q         <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = res_q.action;
	assign pairing_command = res_q.pairing;
	assign program_slot    = res_q.slot;
	assign pressed_status  = res_q.pressed;

	a_start_disables_pairing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_START |-> pairing_command == PAIR_DISABLE)
		else $error("start without pairing disable");

	a_slot_only_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_START |-> program_slot == '0)
		else $error("slot set without start");

	a_enable_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pairing_command == PAIR_ENABLE |-> action == ACT_NONE)
		else $error("pairing enable together with an action");

	a_state_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> flags_q == $past(flags_q))
		else $error("gesture state changed without an item");

endmodule

`default_nettype wire

// File: hw/rtl/btdl_step.sv
`timescale 1ns / 1ps
`default_nettype none

module btdl_step (
	input  wire btdl_pkg::cfg_t              cfg,
	input  wire btdl_pkg::flags_t            flags,
	input  wire logic [btdl_pkg::TimeW-1:0]  tap_time,
	input  wire logic [btdl_pkg::TimeW-1:0]  press_start_time,
	input  wire logic [btdl_pkg::TimeW-1:0]  now_ms,
	input  wire logic                        read_ok,
	input  wire logic                        button_down,
	input  wire logic                        prog_active,
	output btdl_pkg::flags_t                 flags_nxt,
	output logic [btdl_pkg::TimeW-1:0]       tap_time_nxt,
	output logic [btdl_pkg::TimeW-1:0]       press_start_nxt,
	output btdl_pkg::result_t                res
);
	import btdl_pkg::*;

	logic [TimeW-1:0] press_start;
	logic [TimeW-1:0] held;
	logic [TimeW-1:0] gap;
	logic             counts;
	logic             is_long;
	logic             tap_event;
	logic             gap_in;

	always_comb begin
		counts      = flags.was_down ? flags.press_counts : flags.seen_release;
		press_start = flags.status_flag ? press_start_time : now_ms;
		held        = now_ms - press_start;
		is_long     = counts && (held >= {{(TimeW-MsW){1'b0}}, cfg.long_press_ms});
		gap         = now_ms - tap_time;
		gap_in      = gap <= {{(TimeW-MsW){1'b0}}, cfg.double_tap_ms};
		tap_event   = flags.was_down && flags.press_counts && !flags.long_done;
	end

	always_comb begin
		flags_nxt       = flags;
		tap_time_nxt    = tap_time;
		press_start_nxt = press_start_time;
		res.action      = ACT_NONE;
		res.pairing     = PAIR_KEEP;
		res.slot        = '0;
		if (read_ok) begin
			if (!prog_active) begin
				res.pairing = PAIR_DISABLE;
			end
			if (button_down) begin
				flags_nxt.was_down     = 1'b1;
				flags_nxt.press_counts = counts;
				flags_nxt.status_flag  = 1'b1;
				press_start_nxt        = press_start;
				if (is_long) begin
					if (!flags.long_done) begin
						flags_nxt.tap_armed = 1'b0;
						if (prog_active) begin
							res.pairing = PAIR_ENABLE;
						end
					end
					flags_nxt.long_done = 1'b1;
				end
			end else begin
				if (tap_event) begin
					if (flags.tap_armed && gap_in) begin
						// second tap in time
						flags_nxt.tap_armed = 1'b0;
						res.pairing         = PAIR_DISABLE;
						if (prog_active) begin
							if (cfg.stop_enabled) begin
								res.action = ACT_STOP;
							end
						end else begin
							res.action = ACT_START;
							res.slot   = cfg.start_slot;
						end
					end else begin
						flags_nxt.tap_armed = 1'b1;
						tap_time_nxt        = now_ms;
					end
				end else if (flags.tap_armed && !gap_in) begin
					// lone tap expired
					flags_nxt.tap_armed = 1'b0;
					res.action          = ACT_SHUTDOWN;
				end
				flags_nxt.status_flag  = 1'b0;
				flags_nxt.was_down     = 1'b0;
				flags_nxt.press_counts = 1'b0;
				flags_nxt.long_done    = 1'b0;
				flags_nxt.seen_release = 1'b1;
			end
		end
		res.pressed = flags_nxt.status_flag;
	end

endmodule

`default_nettype wire
